// ===== hw/rtl/msfl_pkg.sv =====
// Shared types and constants for the multi-stack shared free list.
package msfl_pkg;

  localparam int NUM_STACKS = 4;
  localparam int NUM_SLOTS  = 256;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int PTR_W   = SLOT_W + 1;
  localparam int STACK_W = 2;
  localparam int DATA_W  = 32;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Write request into the slot store.
  typedef struct packed {
    logic              en;
    logic              value_en;
    logic [SLOT_W-1:0] addr;
    logic [PTR_W-1:0]  link;
    logic [DATA_W-1:0] value;
  } slot_wr_t;

endpackage

// ===== hw/rtl/msfl_slot_store.sv =====
// Slot store: value memory, link memory and per-slot link valid bits.
module msfl_slot_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [msfl_pkg::SLOT_W-1:0]       rd_addr,
  output logic [msfl_pkg::PTR_W-1:0]        link_rd,
  output logic [msfl_pkg::DATA_W-1:0]       value_rd,
  input  msfl_pkg::slot_wr_t                wr
);

  logic [msfl_pkg::DATA_W-1:0] values [msfl_pkg::NUM_SLOTS];
  logic [msfl_pkg::PTR_W-1:0]  links  [msfl_pkg::NUM_SLOTS];
  logic [msfl_pkg::NUM_SLOTS-1:0] link_valid;

  // A link never written reads as the next slot; the last slot thus reads as null.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
    end else if (wr.en) begin
      link_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      links[wr.addr] <= wr.link;
    end
    if (wr.en && wr.value_en) begin
      values[wr.addr] <= wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (link_valid[rd_addr]) begin
        link_rd <= links[rd_addr];
      end else begin
        link_rd <= {1'b0, rd_addr} + msfl_pkg::PTR_W'(1);
      end
      value_rd <= values[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/multi_stack_shared_free_list_core.sv =====
// Top level: several stacks sharing one slot store through linked lists and a free list.
// Each item reads the slot store in the accept cycle; the update state then writes it
// back, updates the head pointers and loads the result register, waiting while the
// result register is full and not being read. No new item is accepted meanwhile.
// Reset (synchronous, active high) empties all stacks and chains every slot onto the
// free list at once through per-slot link valid bits; no clearing pass is needed.
module multi_stack_shared_free_list_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] stack_index, [33:2] push_value, [39:34] zero
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] pop_value
  output logic        m_tuser    // [0] success
);

  // Item fields as they arrive.
  logic [msfl_pkg::STACK_W-1:0] in_idx;
  logic [msfl_pkg::DATA_W-1:0]  in_value;
  msfl_pkg::cmd_t               in_cmd;

  assign in_idx   = s_tdata[1:0];
  assign in_value = s_tdata[33:2];
  assign in_cmd   = msfl_pkg::cmd_t'(s_tuser);

  msfl_pkg::state_t state, state_next;

  // Stack tops and free-list head; null is NUM_SLOTS.
  logic [msfl_pkg::PTR_W-1:0] heads [msfl_pkg::NUM_STACKS];
  logic [msfl_pkg::PTR_W-1:0] free_head;

  // The item being worked on.
  msfl_pkg::cmd_t               cmd;
  logic [msfl_pkg::STACK_W-1:0] idx;
  logic [msfl_pkg::DATA_W-1:0]  value;
  logic                         ok;
  logic [msfl_pkg::SLOT_W-1:0]  slot;

  // Lookup done in the accept cycle, straight from the incoming fields.
  logic                        accept;
  logic                        idx_ok;
  logic [msfl_pkg::PTR_W-1:0]  sel_ptr;
  logic                        sel_ok;

  // Slot store signals.
  logic [msfl_pkg::PTR_W-1:0]  link_rd;
  logic [msfl_pkg::DATA_W-1:0] value_rd;
  msfl_pkg::slot_wr_t          wr;

  logic finish;

  assign s_tready = (state == msfl_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // A stack number beyond the configured count names no stack, and that item fails.
  assign idx_ok  = (int'(in_idx) < msfl_pkg::NUM_STACKS);
  assign sel_ptr = (in_cmd == msfl_pkg::CMD_PUSH) ? free_head : heads[in_idx];
  assign sel_ok  = idx_ok && (sel_ptr != msfl_pkg::NIL);

  // The item completes once the result register is free or being emptied.
  assign finish = (state == msfl_pkg::ST_UPDATE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msfl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      msfl_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = msfl_pkg::ST_UPDATE;
        end
      end
      msfl_pkg::ST_UPDATE: begin
        if (finish) begin
          state_next = msfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = msfl_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture the item and the outcome of its lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd   <= in_cmd;
      idx   <= in_idx;
      value <= in_value;
      ok    <= sel_ok;
      slot  <= sel_ptr[msfl_pkg::SLOT_W-1:0];
    end
  end

  // A push links the new slot to the old top of its stack and stores the value.
  // A pop hands its slot back to the free list by linking it to the old free head.
  always_comb begin
    wr.en       = finish && ok;
    wr.value_en = (cmd == msfl_pkg::CMD_PUSH);
    wr.addr     = slot;
    wr.link     = (cmd == msfl_pkg::CMD_PUSH) ? heads[idx] : free_head;
    wr.value    = value;
  end

  msfl_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && sel_ok),
    .rd_addr  (sel_ptr[msfl_pkg::SLOT_W-1:0]),
    .link_rd  (link_rd),
    .value_rd (value_rd),
    .wr       (wr)
  );

  // Pointer updates. The link read from the slot store is the new free head after a
  // push and the new stack top after a pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      for (int i = 0; i < msfl_pkg::NUM_STACKS; i++) begin
        heads[i] <= msfl_pkg::NIL;
      end
    end else if (finish && ok) begin
      if (cmd == msfl_pkg::CMD_PUSH) begin
        free_head  <= link_rd;
        heads[idx] <= {1'b0, slot};
      end else begin
        free_head  <= {1'b0, slot};
        heads[idx] <= link_rd;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= ok;
      if (cmd == msfl_pkg::CMD_PUSH) begin
        m_tdata <= '0;
      end else if (ok) begin
        m_tdata <= value_rd;
      end else begin
        m_tdata <= '1;
      end
    end
  end

endmodule

// ===== bench/msfl_checker.sv =====
// Checker for the multi-stack free list: predicts each reply and compares it.
module msfl_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] stack_index, [33:2] push_value, [39:34] zero
  input  logic        s_tuser,   // [0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] pop_value
  input  logic        m_tuser,   // [0] success
  output int          accepted_items,
  output int          outstanding,
  output int          failures,
  output int          pushes_stored,
  output int          pushes_refused,
  output int          pops_found,
  output int          pops_empty
);

  typedef struct packed {
    logic                        success;
    logic [msfl_pkg::DATA_W-1:0] value;
  } reply_t;

  // Private copy of the slot store, stack tops and free list.
  logic [msfl_pkg::DATA_W-1:0] slot_data [msfl_pkg::NUM_SLOTS];
  logic [msfl_pkg::PTR_W-1:0]  slot_link [msfl_pkg::NUM_SLOTS];
  logic [msfl_pkg::PTR_W-1:0]  stack_top [msfl_pkg::NUM_STACKS];
  logic [msfl_pkg::PTR_W-1:0]  free_top;

  reply_t expected_replies[$];

  function automatic void clear_stacks();
    for (int i = 0; i < msfl_pkg::NUM_SLOTS; i++) begin
      slot_data[i] = '0;
      slot_link[i] = msfl_pkg::PTR_W'(i + 1);
    end
    for (int i = 0; i < msfl_pkg::NUM_STACKS; i++) begin
      stack_top[i] = msfl_pkg::NIL;
    end
    free_top = '0;
  endfunction

  function automatic reply_t apply_stack_op(msfl_pkg::cmd_t op,
                                            logic [msfl_pkg::STACK_W-1:0] idx,
                                            logic [msfl_pkg::DATA_W-1:0] din);
    reply_t r;
    logic [msfl_pkg::SLOT_W-1:0] slot;
    r.success = 1'b0;
    r.value   = '0;
    if (op == msfl_pkg::CMD_PUSH) begin
      if (int'(idx) < msfl_pkg::NUM_STACKS && free_top != msfl_pkg::NIL) begin
        slot           = free_top[msfl_pkg::SLOT_W-1:0];
        free_top       = slot_link[slot];
        slot_data[slot] = din;
        slot_link[slot] = stack_top[idx];
        stack_top[idx]  = {1'b0, slot};
        r.success      = 1'b1;
        pushes_stored++;
      end else begin
        pushes_refused++;
      end
    end else begin
      if (int'(idx) >= msfl_pkg::NUM_STACKS || stack_top[idx] == msfl_pkg::NIL) begin
        r.value = '1;
        pops_empty++;
      end else begin
        slot            = stack_top[idx][msfl_pkg::SLOT_W-1:0];
        stack_top[idx]  = slot_link[slot];
        slot_link[slot] = free_top;
        free_top        = {1'b0, slot};
        r.success       = 1'b1;
        r.value         = slot_data[slot];
        pops_found++;
      end
    end
    return r;
  endfunction

  function automatic void report(string what, logic [msfl_pkg::DATA_W-1:0] want,
                                 logic [msfl_pkg::DATA_W-1:0] got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  // Counters are written here at the rising edge and read by the top at the falling edge.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      clear_stacks();
      expected_replies.delete();
      accepted_items = 0;
      outstanding    = 0;
      failures       = 0;
      pushes_stored  = 0;
      pushes_refused = 0;
      pops_found     = 0;
      pops_empty     = 0;
    end else begin
      // The reply leaving now always belongs to an older item, so check it first.
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          report("unexpected reply (pop_value)", '0, m_tdata);
        end else begin
          want = expected_replies.pop_front();
          if (m_tuser !== want.success) begin
            report("success", msfl_pkg::DATA_W'(want.success), msfl_pkg::DATA_W'(m_tuser));
          end
          if (m_tdata !== want.value) begin
            report("pop_value", want.value, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_stack_op(msfl_pkg::cmd_t'(s_tuser), s_tdata[1:0], s_tdata[33:2]);
        expected_replies.push_back(want);
        accepted_items++;
      end
      outstanding = expected_replies.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives push and pop items into the core and gives the verdict.
module tb_top;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [1:0] stack_index, [33:2] push_value, [39:34] zero
  logic        s_tuser;   // [0] command
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] pop_value
  logic        m_tuser;   // [0] success

  int accepted_items, outstanding, failures;
  int pushes_stored, pushes_refused, pops_found, pops_empty;

  int  items_sent;
  int  drain_pauses;
  int  ready_hold;
  bit  calm;   // no new idling started on either side while set

  multi_stack_shared_free_list_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  msfl_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .accepted_items (accepted_items),
    .outstanding    (outstanding),
    .failures       (failures),
    .pushes_stored  (pushes_stored),
    .pushes_refused (pushes_refused),
    .pops_found     (pops_found),
    .pops_empty     (pops_empty)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short stalls, now and then a long one.
  function automatic int stall_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 99) < 60) begin
      return 0;
    end
    return stall_len();
  endfunction

  // Called at a falling edge; returns at the falling edge after the item was taken.
  // When there is no gap, tvalid simply stays high and only the payload changes.
  task automatic send(msfl_pkg::cmd_t op, logic [msfl_pkg::STACK_W-1:0] idx,
                      logic [msfl_pkg::DATA_W-1:0] din);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, din, idx};
    items_sent++;
    do @(negedge clk); while (accepted_items < items_sent);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    drain_pauses++;
    while (outstanding != 0) @(negedge clk);
  endtask

  // push_pct sets how often an item is a push; the rest are pops.
  task automatic run_segment(int count, int push_pct, bit quiet);
    calm = quiet;
    repeat (count) begin
      send(($urandom_range(0, 99) < push_pct) ? msfl_pkg::CMD_PUSH : msfl_pkg::CMD_POP,
           msfl_pkg::STACK_W'($urandom_range(0, 3)), msfl_pkg::DATA_W'($urandom));
    end
    calm = 1'b0;
  endtask

  // Receiver side: random back-pressure on the reply channel.
  initial begin
    m_tready   = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (ready_hold > 0) begin
        m_tready <= 1'b0;
        ready_hold--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) begin
          ready_hold = stall_len();
        end
      end
    end
  end

  initial begin
    int pcts[5];
    pcts = '{10, 35, 50, 65, 90};
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    calm         = 1'b0;
    items_sent   = 0;
    drain_pauses = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty stacks first, then extreme values and LIFO order, then slot reuse.
    for (int i = 0; i < msfl_pkg::NUM_STACKS; i++) begin
      send(msfl_pkg::CMD_POP, msfl_pkg::STACK_W'(i), 32'hFFFF_FFFF);
    end
    send(msfl_pkg::CMD_PUSH, 2'd0, 32'h7FFF_FFFF);
    send(msfl_pkg::CMD_PUSH, 2'd1, 32'h8000_0000);
    send(msfl_pkg::CMD_PUSH, 2'd2, 32'h0000_0000);
    send(msfl_pkg::CMD_PUSH, 2'd3, 32'hFFFF_FFFF);
    send(msfl_pkg::CMD_PUSH, 2'd0, 32'h5555_5555);
    send(msfl_pkg::CMD_PUSH, 2'd1, 32'hAAAA_AAAA);
    send(msfl_pkg::CMD_POP,  2'd0, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd0, 32'h1234_5678);
    send(msfl_pkg::CMD_POP,  2'd0, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd1, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd2, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd3, 32'h0000_0000);
    send(msfl_pkg::CMD_PUSH, 2'd3, 32'h0F0F_F0F0);
    send(msfl_pkg::CMD_POP,  2'd3, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd1, 32'h0000_0000);
    send(msfl_pkg::CMD_POP,  2'd1, 32'h0000_0000);

    // Overfill the store so pushes get refused, hold until drained, then empty it.
    run_segment(280, 100, 1'b0);
    wait_drained();
    run_segment(300, 3, 1'b0);

    while (items_sent < 1320) begin
      run_segment($urandom_range(40, 120), pcts[$urandom_range(0, 4)],
                  $urandom_range(0, 3) == 0);
    end

    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d items: %0d pushes stored, %0d refused on a full store,",
             items_sent, pushes_stored, pushes_refused);
    $display("%0d pops returned data, %0d hit an empty stack; %0d drain pause(s).",
             pops_found, pops_empty, drain_pauses);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5000000;
    $display("Timeout with %0d replies still outstanding.", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/msfl_pkg.sv
hw/rtl/msfl_slot_store.sv
hw/rtl/multi_stack_shared_free_list_core.sv
bench/msfl_checker.sv
bench/tb_top.sv
